>>> rtl/lsfp_pkg.sv
// Shared types and constants of the scanner frame parser.
// No dependencies.
package lsfp_pkg;

    localparam logic [7:0]  MAGIC0 = 8'hAF;
    localparam logic [7:0]  MAGIC1 = 8'hFE;
    localparam logic [7:0]  MAGIC2 = 8'hC0;
    localparam logic [7:0]  MAGIC3 = 8'hC2;
    localparam logic [15:0] TYPE_SCAN = 16'h2201;
    localparam logic [15:0] TYPE_ACK  = 16'h2020;
    localparam logic [31:0] HEADER_BYTES      = 32'd24;
    localparam logic [31:0] SCAN_HEADER_BYTES = 32'd46;
    localparam logic [4:0]  POINT_LAST_BYTE   = 5'd23;
    localparam logic [15:0] ANGLE_HALF = 16'd5760;
    localparam logic [15:0] ANGLE_FULL = 16'd11520;

    localparam logic [2:0] KIND_POINT   = 3'd0;
    localparam logic [2:0] KIND_ACK_OK  = 3'd1;
    localparam logic [2:0] KIND_ACK_BAD = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [1:0] INT_NONE  = 2'd0;
    localparam logic [1:0] INT_WIDTH = 2'd1;
    localparam logic [1:0] INT_ECHO  = 2'd2;
    localparam logic [1:0] INT_LAYER = 2'd3;

    localparam logic [1:0] REG_LAYER = 2'd0;
    localparam logic [1:0] REG_ECHO  = 2'd1;
    localparam logic [1:0] REG_INT   = 2'd2;
    localparam logic [1:0] REG_MAX   = 2'd3;

    // Event from the parser to the formatter
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] scan;
        logic [7:0]  layer;
        logic [7:0]  echo;
        logic [15:0] angle;
        logic [15:0] range_cm;
        logic [15:0] width;
        logic        last;
    } evt_t;

    // Finished result
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] scan;
        logic [7:0]  layer;
        logic [7:0]  echo;
        logic [15:0] angle;
        logic [15:0] range_cm;
        logic [7:0]  inten;
        logic        last;
    } res_t;

    // Filter and intensity settings
    typedef struct packed {
        logic [8:0] layer_sel;
        logic [8:0] echo_sel;
        logic [1:0] int_mode;
    } flt_cfg_t;

endpackage

>>> rtl/lsfp_fifo.sv
// Small register queue used between parser, formatter and result port.
// No dependencies.
module lsfp_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    // Store written entry
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if ((wr_en && !full) && !(rd_en && !empty))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!(wr_en && !full) && (rd_en && !empty))
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

>>> rtl/lsfp_front.sv
// Byte parser: magic hunt, header capture, scan header checks, point capture.
// Depends on lsfp_pkg.
module lsfp_front import lsfp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic [31:0] max_payload,
    output logic        evt_valid,
    output evt_t        evt
);
    logic [1:0]  match_reg, match_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] scan_reg, scan_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] done_reg, done_next;
    logic [4:0]  pidx_reg, pidx_next;
    logic [7:0]  lay_reg, lay_next, ech_reg, ech_next;
    logic [15:0] ang_reg, ang_next, dist_reg, dist_next, wid_reg, wid_next;
    logic        valid_reg, valid_next, inpay_reg, inpay_next, fail_reg, fail_next;

    logic [7:0]  magic_exp;
    logic [31:0] expect_size;
    logic        last_byte;
    logic        fail_now;
    logic [15:0] done_inc;

    always_comb
    begin
        case (match_reg)
            2'd0:    magic_exp = MAGIC0;
            2'd1:    magic_exp = MAGIC1;
            2'd2:    magic_exp = MAGIC2;
            default: magic_exp = MAGIC3;
        endcase
    end

    assign expect_size = SCAN_HEADER_BYTES + {12'd0, total_reg, 4'd0}
                       + {13'd0, total_reg, 3'd0};
    assign last_byte   = (idx_reg == size_reg - 32'd1);
    assign done_inc    = done_reg + 16'd1;

    // Next state and event for one accepted byte
    always_comb
    begin
        match_next = match_reg;
        idx_next   = idx_reg;
        size_next  = size_reg;
        type_next  = type_reg;
        scan_next  = scan_reg;
        total_next = total_reg;
        done_next  = done_reg;
        pidx_next  = pidx_reg;
        lay_next   = lay_reg;
        ech_next   = ech_reg;
        ang_next   = ang_reg;
        dist_next  = dist_reg;
        wid_next   = wid_reg;
        valid_next = valid_reg;
        inpay_next = inpay_reg;
        fail_next  = fail_reg;
        fail_now   = fail_reg;
        evt_valid  = 1'b0;
        evt        = '0;
        if (in_valid)
        begin
            if (!valid_reg)
            begin
                // Hunt the magic word
                if (in_byte == magic_exp)
                begin
                    if (match_reg == 2'd3)
                    begin
                        match_next = '0;
                        valid_next = 1'b1;
                        inpay_next = 1'b0;
                        idx_next   = 32'd4;
                        size_next  = '0;
                        type_next  = '0;
                        scan_next  = '0;
                        total_next = '0;
                        done_next  = '0;
                        pidx_next  = '0;
                        fail_next  = 1'b0;
                    end
                    else
                    begin
                        match_next = match_reg + 2'd1;
                    end
                end
                else
                begin
                    match_next = (in_byte == MAGIC0) ? 2'd1 : 2'd0;
                end
            end
            else if (!inpay_reg)
            begin
                // Capture frame header
                if (idx_reg >= 32'd8 && idx_reg <= 32'd11)
                begin
                    size_next = {size_reg[23:0], in_byte};
                end
                else if (idx_reg == 32'd14 || idx_reg == 32'd15)
                begin
                    type_next = {type_reg[7:0], in_byte};
                end
                idx_next = idx_reg + 32'd1;
                if (idx_reg == HEADER_BYTES - 32'd1)
                begin
                    inpay_next = 1'b1;
                    idx_next   = '0;
                    if (size_reg > max_payload ||
                        (type_reg == TYPE_SCAN && size_reg < SCAN_HEADER_BYTES))
                    begin
                        valid_next = 1'b0;
                        inpay_next = 1'b0;
                        evt_valid  = 1'b1;
                        evt.kind   = KIND_ERROR;
                    end
                    else if (size_reg == '0)
                    begin
                        valid_next = 1'b0;
                        inpay_next = 1'b0;
                        evt_valid  = 1'b1;
                        evt.kind   = (type_reg == TYPE_ACK) ?
                                     (fail_reg ? KIND_ACK_BAD : KIND_ACK_OK) : KIND_UNKNOWN;
                    end
                end
            end
            else if (type_reg == TYPE_SCAN)
            begin
                idx_next = idx_reg + 32'd1;
                if (idx_reg < SCAN_HEADER_BYTES)
                begin
                    // Scan header fields and size check
                    if (idx_reg == 32'd6 || idx_reg == 32'd7)
                    begin
                        scan_next = {scan_reg[7:0], in_byte};
                    end
                    else if (idx_reg == 32'd34 || idx_reg == 32'd35)
                    begin
                        total_next = {total_reg[7:0], in_byte};
                    end
                    if (idx_reg == SCAN_HEADER_BYTES - 32'd1)
                    begin
                        if (size_reg == SCAN_HEADER_BYTES)
                        begin
                            valid_next = 1'b0;
                            inpay_next = 1'b0;
                            evt_valid  = 1'b1;
                            evt.kind   = KIND_EMPTY;
                            evt.scan   = scan_reg;
                        end
                        else if (size_reg != expect_size)
                        begin
                            valid_next = 1'b0;
                            inpay_next = 1'b0;
                            evt_valid  = 1'b1;
                            evt.kind   = KIND_ERROR;
                        end
                        pidx_next = '0;
                    end
                end
                else
                begin
                    // Point record bytes
                    case (pidx_reg)
                        5'd2:    lay_next = in_byte;
                        5'd3:    ech_next = in_byte;
                        5'd4:    ang_next[15:8] = in_byte;
                        5'd5:    ang_next[7:0] = in_byte;
                        5'd6:    dist_next[15:8] = in_byte;
                        5'd7:    dist_next[7:0] = in_byte;
                        5'd8:    wid_next[15:8] = in_byte;
                        5'd9:    wid_next[7:0] = in_byte;
                        default: ;
                    endcase
                    if (pidx_reg == POINT_LAST_BYTE)
                    begin
                        pidx_next    = '0;
                        done_next    = done_inc;
                        evt_valid    = 1'b1;
                        evt.kind     = KIND_POINT;
                        evt.scan     = scan_reg;
                        evt.layer    = lay_reg;
                        evt.echo     = ech_reg;
                        evt.angle    = ang_reg;
                        evt.range_cm = dist_reg;
                        evt.width    = wid_reg;
                        evt.last     = (done_inc == total_reg);
                    end
                    else
                    begin
                        pidx_next = pidx_reg + 5'd1;
                    end
                    if (last_byte)
                    begin
                        valid_next = 1'b0;
                        inpay_next = 1'b0;
                        match_next = '0;
                    end
                end
            end
            else
            begin
                // Ack or unknown payload
                idx_next = idx_reg + 32'd1;
                if (type_reg == TYPE_ACK && idx_reg == 32'd1)
                begin
                    fail_next = in_byte[7];
                    fail_now  = in_byte[7];
                end
                if (last_byte)
                begin
                    valid_next = 1'b0;
                    inpay_next = 1'b0;
                    evt_valid  = 1'b1;
                    evt.kind   = (type_reg == TYPE_ACK) ?
                                 (fail_now ? KIND_ACK_BAD : KIND_ACK_OK) : KIND_UNKNOWN;
                end
            end
            if (valid_reg && !valid_next)
            begin
                match_next = '0;
                idx_next   = '0;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            idx_reg   <= '0;
            size_reg  <= '0;
            type_reg  <= '0;
            scan_reg  <= '0;
            total_reg <= '0;
            done_reg  <= '0;
            pidx_reg  <= '0;
            valid_reg <= 1'b0;
            inpay_reg <= 1'b0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            idx_reg   <= idx_next;
            size_reg  <= size_next;
            type_reg  <= type_next;
            scan_reg  <= scan_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            pidx_reg  <= pidx_next;
            valid_reg <= valid_next;
            inpay_reg <= inpay_next;
            fail_reg  <= fail_next;
        end
    end

    // Point field registers
    always_ff @(posedge clk)
    begin
        lay_reg  <= lay_next;
        ech_reg  <= ech_next;
        ang_reg  <= ang_next;
        dist_reg <= dist_next;
        wid_reg  <= wid_next;
    end
endmodule

>>> rtl/lsfp_back.sv
// Formatter: point filter, angle wrap and intensity selection.
// Depends on lsfp_pkg.
module lsfp_back import lsfp_pkg::*; (
    input  evt_t     evt,
    input  flt_cfg_t cfg,
    output logic     keep,
    output res_t     res
);
    logic [15:0] ang;

    // Wrap angles above half a turn
    assign ang = (evt.angle > ANGLE_HALF && !evt.angle[15]) ?
                 evt.angle - ANGLE_FULL : evt.angle;

    always_comb
    begin
        res      = '0;
        res.kind = evt.kind;
        res.scan = evt.scan;
        keep     = 1'b1;
        if (evt.kind == KIND_POINT)
        begin
            // Drop points that fail the layer or echo filter
            if (!(cfg.layer_sel == 9'h1FF || cfg.layer_sel == {1'b0, evt.layer}) ||
                !(cfg.echo_sel == 9'h1FF || cfg.echo_sel == {1'b0, evt.echo}))
            begin
                keep = 1'b0;
            end
            res.layer    = evt.layer;
            res.echo     = evt.echo;
            res.angle    = ang;
            res.range_cm = evt.range_cm;
            res.last     = evt.last;
            case (cfg.int_mode)
                INT_WIDTH: res.inten = (evt.width > 16'd255) ? 8'd255 : evt.width[7:0];
                INT_ECHO:  res.inten = evt.echo;
                INT_LAYER: res.inten = evt.layer;
                default:   res.inten = 8'd0;
            endcase
        end
    end
endmodule

>>> rtl/laser_scan_frame_parser_top.sv
// Top level of the scanner frame parser: configuration registers and queues.
// Depends on lsfp_pkg, lsfp_front, lsfp_fifo and lsfp_back.
//
// Takes one stream byte per cycle whenever full is low; the parser decides
// each byte in the cycle it arrives and posts at most one event into an event
// queue of EVT_DEPTH entries. The formatter drains one event per cycle into a
// result queue of RES_DEPTH entries while that queue has room or the event
// is filtered out, so the sustained rate is one byte per clock; each result
// is registered in the event queue, then the result queue. full rises only
// when the event queue fills because results are not being popped.
module laser_scan_frame_parser_top import lsfp_pkg::*; #(
    parameter int EVT_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  stream_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [15:0] scan_number,
    output logic [7:0]  point_layer,
    output logic [7:0]  point_echo,
    output logic signed [15:0] angle_ticks,
    output logic [15:0] point_range,
    output logic [7:0]  intensity_value,
    output logic        last_point
);
    logic [8:0]  layer_sel_reg, echo_sel_reg;
    logic [1:0]  int_mode_reg;
    logic [31:0] max_pay_reg;
    logic        wr;

    evt_t     evt_in, evt_out;
    logic     evt_push, evt_full, evt_empty, evt_pop;
    flt_cfg_t flt;
    logic     keep, res_full;
    res_t     res_in, res_out;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_sel_reg <= 9'h1FF;
            echo_sel_reg  <= 9'h1FF;
            int_mode_reg  <= INT_WIDTH;
            max_pay_reg   <= 32'd99976;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_LAYER: layer_sel_reg <= pwdata[8:0];
                REG_ECHO:  echo_sel_reg  <= pwdata[8:0];
                REG_INT:   int_mode_reg  <= pwdata[1:0];
                REG_MAX:   max_pay_reg   <= pwdata;
                default:   ;
            endcase
        end
    end

    // Read back configuration
    always_comb
    begin
        unique case (paddr[3:2])
            REG_LAYER: prdata = {{23{layer_sel_reg[8]}}, layer_sel_reg};
            REG_ECHO:  prdata = {{23{echo_sel_reg[8]}}, echo_sel_reg};
            REG_INT:   prdata = {30'd0, int_mode_reg};
            REG_MAX:   prdata = max_pay_reg;
            default:   prdata = '0;
        endcase
    end

    assign full = evt_full;

    lsfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (push && !evt_full),
        .in_byte     (stream_byte),
        .max_payload (max_pay_reg),
        .evt_valid   (evt_push),
        .evt         (evt_in)
    );

    lsfp_fifo #(.DEPTH(EVT_DEPTH), .WIDTH($bits(evt_t))) u_evt_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evt_push),
        .wr_data (evt_in),
        .rd_en   (evt_pop),
        .rd_data (evt_out),
        .full    (evt_full),
        .empty   (evt_empty)
    );

    assign flt.layer_sel = layer_sel_reg;
    assign flt.echo_sel  = echo_sel_reg;
    assign flt.int_mode  = int_mode_reg;

    lsfp_back u_back (
        .evt  (evt_out),
        .cfg  (flt),
        .keep (keep),
        .res  (res_in)
    );

    // Drain an event when its result fits, or drop it outright when filtered
    assign evt_pop = !evt_empty && (!keep || !res_full);

    lsfp_fifo #(.DEPTH(RES_DEPTH), .WIDTH($bits(res_t))) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evt_pop && keep),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign result_kind     = res_out.kind;
    assign scan_number     = res_out.scan;
    assign point_layer     = res_out.layer;
    assign point_echo      = res_out.echo;
    assign angle_ticks     = res_out.angle;
    assign point_range     = res_out.range_cm;
    assign intensity_value = res_out.inten;
    assign last_point      = res_out.last;
endmodule
